@@ rtl/wos_pkg.sv @@
`default_nettype none
package wos_pkg;

   localparam int MAX_LEN    = 64;
   localparam int DATA_WIDTH = 32;
   localparam int CNT_W      = $clog2(MAX_LEN + 1);

   typedef logic signed [DATA_WIDTH-1:0] data_type;
   typedef logic [CNT_W-1:0]             cnt_type;

   typedef struct packed {
      logic     ins;
      logic     shift;
      logic     clr;
      data_type value;
   } cell_ctl_type;

endpackage
`default_nettype wire

@@ rtl/wos_cell.sv @@
`default_nettype none
module wos_cell
   import wos_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire cell_ctl_type ctl,
   input  wire data_type     prev_data,
   input  wire logic         prev_valid,
   input  wire logic         prev_lt,
   input  wire data_type     next2_data,
   input  wire logic         next2_valid,
   output data_type          data,
   output logic              valid,
   output logic              lt
);

   data_type data_ff, data_in;
   logic     valid_ff, valid_in;

   // invalid cells act as +infinity
   assign lt    = !valid_ff || (ctl.value < data_ff);
   assign data  = data_ff;
   assign valid = valid_ff;

   always_comb begin
      data_in  = data_ff;
      valid_in = valid_ff;
      if (ctl.clr) begin
         valid_in = 1'b0;
      end else if (ctl.shift) begin
         data_in  = next2_data;
         valid_in = next2_valid;
      end else if (ctl.ins && lt) begin
         data_in  = prev_lt ? prev_data : ctl.value;
         valid_in = valid_ff | prev_valid;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

endmodule
`default_nettype wire

@@ rtl/wave_order_sort.sv @@
`default_nettype none
// Wave-order sorter. Elements stream in one per cycle and are insertion-sorted
// on the fly by a row of MAX_LEN compare cells, so an element is taken in
// every clock while the list is being collected. The transfer carrying tlast
// closes the list; the block then stops taking input and streams the list out
// in wave order (sorted, each adjacent pair swapped, an odd last element in
// place), one element per cycle that the sink is ready, with tlast on the
// final one. A list thus holds the input off for one output transfer per kept
// element. Elements beyond MAX_LEN are dropped and tuser (overflow) is set on
// every result of that list.
module wave_order_sort
   import wos_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // [31:0] value
   input  wire logic        req_tlast,   // final_item
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // [31:0] value_res
   output logic             rsp_tlast,   // final_item_res
   output logic             rsp_tuser    // overflow
);

   cell_ctl_type ctl;
   data_type     c_data  [MAX_LEN];
   logic         c_valid [MAX_LEN];
   logic         c_lt    [MAX_LEN];

   logic    emit_ff, emit_in;
   logic    odd_ff, odd_in;
   logic    ovf_ff, ovf_in;
   cnt_type cnt_ff, cnt_in;
   cnt_type left_ff, left_in;

   logic req_xfer, rsp_xfer, room;

   assign req_tready = !emit_ff;
   assign req_xfer   = req_tvalid && req_tready;
   assign rsp_xfer   = rsp_tvalid && rsp_tready;
   assign room       = cnt_ff < CNT_W'(MAX_LEN);

   assign ctl.value = data_type'(req_tdata);
   assign ctl.ins   = req_xfer && room;
   assign ctl.shift = rsp_xfer && odd_ff;
   assign ctl.clr   = rsp_xfer && (left_ff == CNT_W'(1));

   genvar i;
   generate
      for (i = 0; i < MAX_LEN; i++) begin : g_cell
         data_type p_data, n_data;
         logic     p_valid, p_lt, n_valid;
         if (i == 0) begin : g_head
            assign p_data  = '0;
            assign p_valid = 1'b1;
            assign p_lt    = 1'b0;
         end else begin : g_mid
            assign p_data  = c_data[i-1];
            assign p_valid = c_valid[i-1];
            assign p_lt    = c_lt[i-1];
         end
         if (i + 2 < MAX_LEN) begin : g_body
            assign n_data  = c_data[i+2];
            assign n_valid = c_valid[i+2];
         end else begin : g_tail
            assign n_data  = '0;
            assign n_valid = 1'b0;
         end
         wos_cell u_cell (
            .clock       (clock),
            .reset       (reset),
            .ctl         (ctl),
            .prev_data   (p_data),
            .prev_valid  (p_valid),
            .prev_lt     (p_lt),
            .next2_data  (n_data),
            .next2_valid (n_valid),
            .data        (c_data[i]),
            .valid       (c_valid[i]),
            .lt          (c_lt[i])
         );
      end
   endgenerate

   // even position with a partner: take the upper of the pair first
   assign rsp_tvalid = emit_ff;
   assign rsp_tdata  = (!odd_ff && (left_ff >= CNT_W'(2))) ? 32'(c_data[1])
                                                           : 32'(c_data[0]);
   assign rsp_tlast  = (left_ff == CNT_W'(1));
   assign rsp_tuser  = ovf_ff;

   always_comb begin
      emit_in = emit_ff;
      odd_in  = odd_ff;
      ovf_in  = ovf_ff;
      cnt_in  = cnt_ff;
      left_in = left_ff;
      if (emit_ff) begin
         if (rsp_xfer) begin
            odd_in  = !odd_ff;
            left_in = left_ff - CNT_W'(1);
            if (left_ff == CNT_W'(1)) begin
               emit_in = 1'b0;
               odd_in  = 1'b0;
               ovf_in  = 1'b0;
               cnt_in  = '0;
            end
         end
      end else if (req_xfer) begin
         if (room) begin
            cnt_in = cnt_ff + CNT_W'(1);
         end else begin
            ovf_in = 1'b1;
         end
         if (req_tlast) begin
            emit_in = 1'b1;
            odd_in  = 1'b0;
            left_in = cnt_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      left_ff <= left_in;
      if (reset) begin
         emit_ff <= 1'b0;
         odd_ff  <= 1'b0;
         ovf_ff  <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         emit_ff <= emit_in;
         odd_ff  <= odd_in;
         ovf_ff  <= ovf_in;
         cnt_ff  <= cnt_in;
      end
   end

endmodule
`default_nettype wire
